### rtl/wmog_pkg.sv
package wmog_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 2);
    localparam int LEN_W      = 7;
    localparam int RAW_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int VAL_W      = 24;
    localparam int SUM_W      = RAW_W + ADDR_W + 1;
    localparam int NUM_W      = SUM_W + FRAC_W;
    localparam int VAR_W      = 2 * VAL_W;
    localparam int ACC_W      = VAR_W + ADDR_W + 1;
    localparam int ROOT_W     = VAL_W + 1;
    localparam int STEP_W     = $clog2(ACC_W + 1);
    localparam int SQ_STEPS   = VAR_W / 2;
    localparam int SQ_CNT_W   = $clog2(SQ_STEPS + 1);
    localparam int LIM_W      = VAL_W + 7;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [LEN_W-1:0] WINDOW_RESET  = 7'd16;
    localparam logic [6:0]       REJECT_SIGMAS = 7'd100;
    localparam logic [VAL_W-1:0] DEV_FLOOR     = 24'd47;
    localparam logic [VAL_W-1:0] DEV_MAX       = 24'hFFFFFF;

    typedef struct packed {
        logic                    restart;
        logic signed [RAW_W-1:0] raw;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_WALK,
        ST_VAR_START,
        ST_VAR_WAIT,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_OUT
    } back_state_t;

    function automatic logic [CNT_W-1:0] clamp_length(input logic [LEN_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (int'(v) > MAX_WINDOW)
            r = CNT_W'(MAX_WINDOW);
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage

### rtl/wmog_if.sv
interface wmog_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    command;
    logic signed [wmog_pkg::RAW_W-1:0]       raw_angle;

    modport source (output valid, output command, output raw_angle, input ready);
    modport sink   (input valid, input command, input raw_angle, output ready);
endinterface

interface wmog_out_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    accepted;
    logic signed [wmog_pkg::VAL_W-1:0]       mean_value;
    logic [wmog_pkg::VAL_W-1:0]              deviation;

    modport source (output valid, output accepted, output mean_value, output deviation,
                    input ready);
    modport sink   (input valid, input accepted, input mean_value, input deviation,
                    output ready);
endinterface

interface wmog_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [wmog_pkg::LEN_W-1:0]              window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

### rtl/wmog_ram.sv
module wmog_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/wmog_div.sv
module wmog_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [wmog_pkg::ACC_W-1:0]         dividend,
    input  logic [wmog_pkg::CNT_W-1:0]         divisor,
    input  logic [wmog_pkg::STEP_W-1:0]        steps,
    output logic                               done,
    output logic [wmog_pkg::ACC_W-1:0]         quotient
);

    logic [wmog_pkg::ACC_W-1:0]  work_reg, work_next;
    logic [wmog_pkg::ACC_W-1:0]  quot_reg, quot_next;
    logic [wmog_pkg::CNT_W-1:0]  rem_reg, rem_next;
    logic [wmog_pkg::CNT_W-1:0]  div_reg, div_next;
    logic [wmog_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [wmog_pkg::CNT_W:0]    trial;
    logic                        take;

    always_comb
    begin
        trial = {rem_reg, work_reg[wmog_pkg::ACC_W-1]};
        take  = trial >= {1'b0, div_reg};
        work_next = work_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = dividend;
            quot_next = '0;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[wmog_pkg::ACC_W-2:0], 1'b0};
            quot_next = {quot_reg[wmog_pkg::ACC_W-2:0], take};
            rem_next  = take ? wmog_pkg::CNT_W'(trial - {1'b0, div_reg})
                             : trial[wmog_pkg::CNT_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == wmog_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### rtl/wmog_sqrt.sv
module wmog_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wmog_pkg::VAR_W-1:0]    radicand,
    output logic                          done,
    output logic [wmog_pkg::ROOT_W-1:0]   root
);

    logic [wmog_pkg::VAR_W-1:0]    v_reg, v_next;
    logic [wmog_pkg::VAR_W-1:0]    r_reg, r_next;
    logic [wmog_pkg::VAR_W-1:0]    bit_reg, bit_next;
    logic [wmog_pkg::SQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [wmog_pkg::VAR_W:0]      trial;
    logic                          take;

    always_comb
    begin
        trial = {1'b0, r_reg} + {1'b0, bit_reg};
        take  = {1'b0, v_reg} >= trial;
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next    = radicand;
            r_next    = '0;
            bit_next  = wmog_pkg::VAR_W'(1) << (wmog_pkg::VAR_W - 2);
            cnt_next  = wmog_pkg::SQ_CNT_W'(wmog_pkg::SQ_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                if (take)
                begin
                    v_next = v_reg - trial[wmog_pkg::VAR_W-1:0];
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                // round to nearest
                if (v_reg > r_reg)
                begin
                    r_next = r_reg + 1'b1;
                end
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg[wmog_pkg::ROOT_W-1:0];

endmodule

### rtl/wmog_front.sv
module wmog_front (
    input  logic            clk,
    input  logic            rst_n,
    wmog_in_if.sink         item,
    output wmog_pkg::item_t head,
    output logic            head_valid,
    input  logic            pop
);

    wmog_pkg::item_t             q_reg [wmog_pkg::QDEPTH];
    logic [wmog_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [wmog_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [wmog_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        push;
    logic                        do_pop;
    wmog_pkg::item_t             incoming;

    assign item.ready = count_reg != wmog_pkg::QCNT_W'(wmog_pkg::QDEPTH);
    assign push       = item.valid && item.ready;
    assign do_pop     = pop && (count_reg != '0);

    always_comb
    begin
        incoming.restart = item.command;
        incoming.raw     = item.raw_angle;
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + wmog_pkg::QCNT_W'(push) - wmog_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = count_reg != '0;

endmodule

### rtl/wmog_back.sv
module wmog_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wmog_pkg::item_t               head,
    input  logic                          head_valid,
    output logic                          pop,
    input  logic [wmog_pkg::LEN_W-1:0]    window_length,
    wmog_out_if.source                    result
);

    wmog_pkg::back_state_t state_reg, state_next;

    logic                                restart_reg;
    logic signed [wmog_pkg::RAW_W-1:0]   raw_reg;
    logic [wmog_pkg::CNT_W-1:0]          active_reg;
    logic [wmog_pkg::CNT_W-1:0]          seen_reg;
    logic [wmog_pkg::ADDR_W-1:0]         wp_reg;
    logic signed [wmog_pkg::SUM_W-1:0]   sum_reg;
    logic signed [wmog_pkg::VAL_W-1:0]   mean_reg;
    logic [wmog_pkg::VAL_W-1:0]          dev_reg;
    logic [wmog_pkg::MAX_WINDOW-1:0]     valid_reg;
    logic [wmog_pkg::CNT_W-1:0]          n_reg;
    logic                                neg_reg;
    logic [wmog_pkg::CNT_W-1:0]          idx_reg;
    logic                                s1_v_reg, s2_v_reg, s3_v_reg;
    logic [wmog_pkg::ADDR_W-1:0]         s1_idx_reg;
    logic [wmog_pkg::VAL_W-1:0]          ad_reg;
    logic [wmog_pkg::VAR_W-1:0]          prod_reg;
    logic [wmog_pkg::ACC_W-1:0]          acc_reg;
    logic [wmog_pkg::VAR_W-1:0]          var_reg;
    logic                                ok_reg;
    logic                                out_valid_reg;
    logic                                out_acc_reg;
    logic signed [wmog_pkg::VAL_W-1:0]   out_mean_reg;
    logic [wmog_pkg::VAL_W-1:0]          out_dev_reg;

    logic                                ram_we;
    logic [wmog_pkg::ADDR_W-1:0]         ram_raddr;
    logic [wmog_pkg::RAW_W-1:0]          ram_rdata;
    logic                                div_start, div_done;
    logic [wmog_pkg::ACC_W-1:0]          div_dividend, div_quot;
    logic [wmog_pkg::STEP_W-1:0]         div_steps;
    logic                                sqrt_start, sqrt_done;
    logic [wmog_pkg::ROOT_W-1:0]         sqrt_root;
    logic                                out_load;
    logic                                issue;
    logic                                walk_done;

    logic [wmog_pkg::CNT_W-1:0]          seen_inc;
    logic signed [wmog_pkg::VAL_W-1:0]   scaled;
    logic signed [wmog_pkg::VAL_W:0]     diff;
    logic [wmog_pkg::VAL_W:0]            mag;
    logic [wmog_pkg::LIM_W-1:0]          limit;
    logic                                reject;
    logic [wmog_pkg::CNT_W-1:0]          n_cand;
    logic signed [wmog_pkg::RAW_W-1:0]   old_s;
    logic signed [wmog_pkg::SUM_W-1:0]   sum_new;
    logic [wmog_pkg::CNT_W-1:0]          wp_ext;
    logic signed [wmog_pkg::NUM_W-1:0]   num;
    logic [wmog_pkg::NUM_W-1:0]          num_mag;
    logic [wmog_pkg::VAL_W-1:0]          q_mean;
    logic signed [wmog_pkg::RAW_W-1:0]   entry;
    logic signed [wmog_pkg::VAL_W:0]     d;
    logic [wmog_pkg::VAL_W:0]            ad;
    logic [wmog_pkg::VAL_W-1:0]          dev_new;

    wmog_ram #(
        .WIDTH (wmog_pkg::RAW_W),
        .DEPTH (wmog_pkg::MAX_WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (raw_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wmog_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_reg),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_quot)
    );

    wmog_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (var_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // datapath terms
    always_comb
    begin
        seen_inc = (seen_reg < active_reg + wmog_pkg::CNT_W'(1)) ? seen_reg + 1'b1 : seen_reg;
        scaled   = {raw_reg, {wmog_pkg::FRAC_W{1'b0}}};
        diff     = {scaled[wmog_pkg::VAL_W-1], scaled} - {mean_reg[wmog_pkg::VAL_W-1], mean_reg};
        mag      = diff[wmog_pkg::VAL_W] ? -diff : diff;
        limit    = wmog_pkg::LIM_W'(dev_reg) * wmog_pkg::LIM_W'(wmog_pkg::REJECT_SIGMAS);
        reject   = (seen_inc > active_reg) && (wmog_pkg::LIM_W'(mag) > limit);
        n_cand   = (seen_inc < active_reg) ? seen_inc : active_reg;

        old_s    = valid_reg[wp_reg] ? ram_rdata : '0;
        sum_new  = sum_reg - wmog_pkg::SUM_W'(old_s) + wmog_pkg::SUM_W'(raw_reg);
        wp_ext   = wmog_pkg::CNT_W'(wp_reg) + 1'b1;

        num      = {sum_reg, {wmog_pkg::FRAC_W{1'b0}}};
        num_mag  = num[wmog_pkg::NUM_W-1] ? -num : num;
        q_mean   = div_quot[wmog_pkg::VAL_W-1:0];

        entry    = valid_reg[s1_idx_reg] ? ram_rdata : '0;
        d        = {entry[wmog_pkg::RAW_W-1], entry, {wmog_pkg::FRAC_W{1'b0}}}
                   - {mean_reg[wmog_pkg::VAL_W-1], mean_reg};
        ad       = d[wmog_pkg::VAL_W] ? -d : d;

        if (sqrt_root < wmog_pkg::ROOT_W'(wmog_pkg::DEV_FLOOR))
            dev_new = wmog_pkg::DEV_FLOOR;
        else if (sqrt_root[wmog_pkg::ROOT_W-1])
            dev_new = wmog_pkg::DEV_MAX;
        else
            dev_new = sqrt_root[wmog_pkg::VAL_W-1:0];

        issue     = idx_reg < n_reg;
        walk_done = !issue && !s1_v_reg && !s2_v_reg && !s3_v_reg;
        out_load  = !out_valid_reg || result.ready;

        if (state_reg == wmog_pkg::ST_VAR_START)
        begin
            div_dividend = acc_reg;
            div_steps    = wmog_pkg::STEP_W'(wmog_pkg::ACC_W);
        end
        else
        begin
            div_dividend = {num_mag + wmog_pkg::NUM_W'(n_reg >> 1),
                            {(wmog_pkg::ACC_W - wmog_pkg::NUM_W){1'b0}}};
            div_steps    = wmog_pkg::STEP_W'(wmog_pkg::NUM_W);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wmog_pkg::ST_IDLE:
                if (head_valid)
                    state_next = wmog_pkg::ST_CHECK;
            wmog_pkg::ST_CHECK:
                if (restart_reg || reject)
                    state_next = wmog_pkg::ST_OUT;
                else
                    state_next = wmog_pkg::ST_READ;
            wmog_pkg::ST_READ:
                state_next = wmog_pkg::ST_MEAN_START;
            wmog_pkg::ST_MEAN_START:
                state_next = wmog_pkg::ST_MEAN_WAIT;
            wmog_pkg::ST_MEAN_WAIT:
                if (div_done)
                    state_next = wmog_pkg::ST_WALK;
            wmog_pkg::ST_WALK:
                if (walk_done)
                    state_next = wmog_pkg::ST_VAR_START;
            wmog_pkg::ST_VAR_START:
                state_next = wmog_pkg::ST_VAR_WAIT;
            wmog_pkg::ST_VAR_WAIT:
                if (div_done)
                    state_next = wmog_pkg::ST_SQRT_START;
            wmog_pkg::ST_SQRT_START:
                state_next = wmog_pkg::ST_SQRT_WAIT;
            wmog_pkg::ST_SQRT_WAIT:
                if (sqrt_done)
                    state_next = wmog_pkg::ST_OUT;
            wmog_pkg::ST_OUT:
                if (out_load)
                    state_next = wmog_pkg::ST_IDLE;
            default:
                state_next = wmog_pkg::ST_IDLE;
        endcase
    end

    // control strobes
    always_comb
    begin
        pop        = 1'b0;
        ram_we     = 1'b0;
        ram_raddr  = idx_reg[wmog_pkg::ADDR_W-1:0];
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        unique case (state_reg)
            wmog_pkg::ST_IDLE:       pop = head_valid;
            wmog_pkg::ST_CHECK:      ram_raddr = wp_reg;
            wmog_pkg::ST_READ:       ram_we = 1'b1;
            wmog_pkg::ST_MEAN_START: div_start = 1'b1;
            wmog_pkg::ST_VAR_START:  div_start = 1'b1;
            wmog_pkg::ST_SQRT_START: sqrt_start = 1'b1;
            default:                 pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wmog_pkg::ST_IDLE;
            active_reg    <= wmog_pkg::clamp_length(wmog_pkg::WINDOW_RESET);
            seen_reg      <= '0;
            wp_reg        <= '0;
            sum_reg       <= '0;
            mean_reg      <= '0;
            dev_reg       <= '0;
            valid_reg     <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= (state_reg == wmog_pkg::ST_WALK) && issue;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            if (state_reg == wmog_pkg::ST_CHECK)
            begin
                if (restart_reg)
                begin
                    active_reg <= wmog_pkg::clamp_length(window_length);
                    seen_reg   <= '0;
                    wp_reg     <= '0;
                    sum_reg    <= '0;
                    mean_reg   <= '0;
                    dev_reg    <= '0;
                    valid_reg  <= '0;
                end
                else
                begin
                    seen_reg <= seen_inc;
                end
            end
            if (state_reg == wmog_pkg::ST_READ)
            begin
                sum_reg           <= sum_new;
                valid_reg[wp_reg] <= 1'b1;
                wp_reg            <= (wp_ext >= active_reg) ? '0
                                     : wp_ext[wmog_pkg::ADDR_W-1:0];
            end
            if (state_reg == wmog_pkg::ST_MEAN_WAIT && div_done)
            begin
                mean_reg <= neg_reg ? -q_mean : q_mean;
            end
            if (state_reg == wmog_pkg::ST_SQRT_WAIT && sqrt_done)
            begin
                dev_reg <= dev_new;
            end
            if (state_reg == wmog_pkg::ST_OUT && out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            restart_reg <= head.restart;
            raw_reg     <= head.raw;
        end
        if (state_reg == wmog_pkg::ST_CHECK)
        begin
            n_reg  <= n_cand;
            ok_reg <= 1'b0;
        end
        if (state_reg == wmog_pkg::ST_MEAN_START)
        begin
            neg_reg <= num[wmog_pkg::NUM_W-1];
        end
        if (state_reg == wmog_pkg::ST_MEAN_WAIT)
        begin
            idx_reg <= '0;
            acc_reg <= '0;
        end
        if (state_reg == wmog_pkg::ST_WALK)
        begin
            if (issue)
                idx_reg <= idx_reg + 1'b1;
            if (s3_v_reg)
                acc_reg <= acc_reg + wmog_pkg::ACC_W'(prod_reg);
        end
        s1_idx_reg <= idx_reg[wmog_pkg::ADDR_W-1:0];
        ad_reg     <= ad[wmog_pkg::VAL_W-1:0];
        prod_reg   <= ad_reg * ad_reg;
        if (state_reg == wmog_pkg::ST_VAR_WAIT && div_done)
        begin
            var_reg <= div_quot[wmog_pkg::VAR_W-1:0];
        end
        if (state_reg == wmog_pkg::ST_SQRT_WAIT && sqrt_done)
        begin
            ok_reg <= 1'b1;
        end
        if (state_reg == wmog_pkg::ST_OUT && out_load)
        begin
            out_acc_reg  <= ok_reg;
            out_mean_reg <= mean_reg;
            out_dev_reg  <= dev_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.accepted   = out_acc_reg;
    assign result.mean_value = out_mean_reg;
    assign result.deviation  = out_dev_reg;

endmodule

### rtl/windowed_mean_outlier_gate.sv
// Windowed mean with sigma-based outlier rejection for tilt-angle samples.
// item:   valid/ready transfer of {command, raw_angle}; command 1 restarts and
//         clears all statistics (window, sum, counters, mean, deviation).
// result: valid/ready transfer of {accepted, mean_value, deviation}, one per item.
// cfg:    valid/ready write of window_length (always ready); it takes effect at
//         the next restart.
// A restart or a rejected sample goes straight to the output register. An
// accepted sample takes two passes through the bit-serial divider (31 steps
// for the mean, 55 for the variance), a walk over the filled entries of the
// window RAM at one entry per cycle, and a 24-step square root. Items are
// handled one at a time, so a new item starts only after the last is done.
// A two-entry queue in front takes items while the back end works, and the
// output register holds a finished result while the receiver stalls; the back
// end waits with the next result until that register is free.
// Reset: window length 16, all statistics zero, window entries read as zero.
module windowed_mean_outlier_gate (
    input  logic        clk,
    input  logic        rst_n,
    wmog_in_if.sink     item,
    wmog_out_if.source  result,
    wmog_cfg_if.sink    cfg
);

    logic [wmog_pkg::LEN_W-1:0] wl_reg;
    wmog_pkg::item_t            head;
    logic                       head_valid;
    logic                       pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wl_reg <= wmog_pkg::WINDOW_RESET;
        else if (cfg.valid)
            wl_reg <= cfg.window_length;
    end

    wmog_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    wmog_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .window_length (wl_reg),
        .result        (result)
    );

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_dev_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.accepted) |-> (result.deviation >= wmog_pkg::DEV_FLOOR))
        else $error("accepted result below deviation floor");

    a_zero_dev: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.deviation == '0) |->
        (result.mean_value == '0 && !result.accepted))
        else $error("zero deviation outside cleared state");
`endif

endmodule
